### hdl/pcf_pkg.sv
// Shared widths, stage counts, carried-info types and step functions for the point charge field.
package pcf_pkg;

    // Field widths
    localparam int CoordW  = 16;
    localparam int DiffW   = 17;
    localparam int AbsW    = 17;
    localparam int SqW     = 34;
    localparam int RootAW  = 31;
    localparam int RootBW  = 16;
    localparam int DenW    = 50;
    localparam int QW      = 29;
    localparam int MagSqW  = 58;
    localparam int PotQW   = 49;
    localparam int PotW    = 25;
    localparam int FieldW  = 40;
    localparam int MagW    = 39;
    localparam int PotOutW = 32;

    // Step counts of each pipelined unit
    localparam int AStep    = 31;
    localparam int BStep    = 16;
    localparam int DivStep  = 29;
    localparam int CStep    = 29;
    localparam int PDivStep = 49;
    localparam int PSqStep  = 25;
    localparam int PDelay   = 34;

    // Flags that ride with an item down the field path
    typedef struct packed {
        logic v;
        logic zero;
        logic nx;
        logic ny;
        logic neg;
    } info_t;

    // Finished values handed to the output stage
    typedef struct packed {
        logic          zero;
        logic          nx;
        logic          ny;
        logic          neg;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic [QW-1:0] mag;
        logic [PotW-1:0] pot;
    } res_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic [63:0] rem;
        logic        q;
    } dv_t;

    // One digit of a restoring square root: bring in two radicand bits
    function automatic sq_t sqrt_step(logic [63:0] rem, logic [31:0] root, logic [1:0] bits);
        sq_t         r;
        logic [63:0] t;
        logic [63:0] trial;
        t     = {rem[61:0], bits};
        trial = {30'b0, root, 2'b01};
        if (t >= trial)
        begin
            r.rem  = t - trial;
            r.root = {root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = t;
            r.root = {root[30:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring divide: bring in one numerator bit
    function automatic dv_t div_step(logic [63:0] rem, logic [63:0] den, logic b);
        dv_t         r;
        logic [63:0] t;
        t = {rem[62:0], b};
        if (t >= den)
        begin
            r.rem = t - den;
            r.q   = 1'b1;
        end
        else
        begin
            r.rem = t;
            r.q   = 1'b0;
        end
        return r;
    endfunction

endpackage

### hdl/pcf_if.sv
// Handshake channels for point items and result items.
interface pcf_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcf_pkg::CoordW-1:0]  charge_x;
    logic signed [pcf_pkg::CoordW-1:0]  charge_y;
    logic signed [pcf_pkg::CoordW-1:0]  point_x;
    logic signed [pcf_pkg::CoordW-1:0]  point_y;
    logic                               negative;
    modport source (output valid, charge_x, charge_y, point_x, point_y, negative, input ready);
    modport sink   (input valid, charge_x, charge_y, point_x, point_y, negative, output ready);
endinterface

interface pcf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcf_pkg::FieldW-1:0]   field_x;
    logic signed [pcf_pkg::FieldW-1:0]   field_y;
    logic        [pcf_pkg::MagW-1:0]     field_magnitude;
    logic signed [pcf_pkg::PotOutW-1:0]  potential_value;
    modport source (output valid, field_x, field_y, field_magnitude, potential_value, input ready);
    modport sink   (input valid, field_x, field_y, field_magnitude, potential_value, output ready);
endinterface

### hdl/point_charge_field_and_potential.sv
// Throughput: one item per cycle; most stages are register steps of a pipelined
// square root, divider or multiplier, and the whole pipeline holds while a result waits.
// The field path sets the latency: two chained square-root digit pipelines (together a fourth root), a multiply,
// a 29-bit divide, a square-sum and a 29-digit square root. Reset clears valid bits and carried flags only.
module point_charge_field_and_potential (
    input  logic       clk,
    input  logic       rst_n,
    pcf_in_if.sink     sample,
    pcf_out_if.source  result
);
    import pcf_pkg::*;

    logic en;
    res_t res;

    // Front stages: differences, then squared distance
    logic signed [DiffW-1:0] dx_reg, dy_reg;
    logic                    neg1_reg;
    logic                    v1_reg;
    logic [SqW-1:0]          s_reg;
    logic [AbsW-1:0]         adx_reg, ady_reg;
    info_t                   info2_reg;
    logic [AbsW-1:0]         adx_c, ady_c;

    assign sample.ready = en;

    always_comb
    begin
        adx_c = dx_reg[DiffW-1] ? AbsW'(-dx_reg) : AbsW'(dx_reg);
        ady_c = dy_reg[DiffW-1] ? AbsW'(-dy_reg) : AbsW'(dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            info2_reg <= '0;
        end
        else if (en)
        begin
            v1_reg         <= sample.valid;
            info2_reg.v    <= v1_reg;
            info2_reg.zero <= (dx_reg == '0) && (dy_reg == '0);
            info2_reg.nx   <= dx_reg[DiffW-1] ^ neg1_reg;
            info2_reg.ny   <= dy_reg[DiffW-1] ^ neg1_reg;
            info2_reg.neg  <= neg1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= DiffW'(sample.point_x) - DiffW'(sample.charge_x);
            dy_reg   <= DiffW'(sample.point_y) - DiffW'(sample.charge_y);
            neg1_reg <= sample.negative;
            s_reg    <= SqW'(adx_c * adx_c) + SqW'(ady_c * ady_c);
            adx_reg  <= adx_c;
            ady_reg  <= ady_c;
        end
    end

    // Info line along the field path
    localparam int FieldLen = AStep + BStep + 1 + DivStep + 2 + CStep;
    info_t info_reg [FieldLen];

    genvar p;
    generate
        for (p = 0; p < FieldLen; p++)
        begin : g_info
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    info_reg[p] <= '0;
                end
                else if (en)
                begin
                    if (p == 0)
                    begin
                        info_reg[p] <= info2_reg;
                    end
                    else
                    begin
                        info_reg[p] <= info_reg[(p == 0) ? 0 : p-1];
                    end
                end
            end
        end
    endgenerate

    // Square root A: sqrt(S * 2^28)
    logic [RootAW:0]   a_rem [AStep];
    logic [RootAW-1:0] a_root[AStep];
    logic [SqW-1:0]    a_s   [AStep];
    logic [AbsW-1:0]   a_adx [AStep];
    logic [AbsW-1:0]   a_ady [AStep];

    genvar k;
    generate
        for (k = 0; k < AStep; k++)
        begin : g_sqa
            logic [63:0]     rem_in;
            logic [31:0]     root_in;
            logic [SqW-1:0]  s_in;
            logic [61:0]     rad;
            sq_t             st;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign s_in    = s_reg;
            end
            else
            begin : g_next
                assign rem_in  = {{(63-RootAW){1'b0}}, a_rem[k-1]};
                assign root_in = {{(32-RootAW){1'b0}}, a_root[k-1]};
                assign s_in    = a_s[k-1];
            end
            assign rad = {s_in, 28'b0};
            assign st  = sqrt_step(rem_in, root_in, rad[61-2*k -: 2]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_rem[k]  <= st.rem[RootAW:0];
                    a_root[k] <= st.root[RootAW-1:0];
                    a_s[k]    <= s_in;
                    if (k == 0)
                    begin
                        a_adx[k] <= adx_reg;
                        a_ady[k] <= ady_reg;
                    end
                    else
                    begin
                        a_adx[k] <= a_adx[(k == 0) ? 0 : k-1];
                        a_ady[k] <= a_ady[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    endgenerate

    // Square root B: fourth root R
    logic [RootBW:0]   b_rem [BStep];
    logic [RootBW-1:0] b_root[BStep];
    logic [RootAW-1:0] b_ra  [BStep];
    logic [SqW-1:0]    b_s   [BStep];
    logic [AbsW-1:0]   b_adx [BStep];
    logic [AbsW-1:0]   b_ady [BStep];

    generate
        for (k = 0; k < BStep; k++)
        begin : g_sqb
            logic [63:0]       rem_in;
            logic [31:0]       root_in;
            logic [RootAW-1:0] ra_in;
            logic [SqW-1:0]    s_in;
            logic [AbsW-1:0]   adx_in, ady_in;
            logic [31:0]       rad;
            sq_t               st;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign ra_in   = a_root[AStep-1];
                assign s_in    = a_s[AStep-1];
                assign adx_in  = a_adx[AStep-1];
                assign ady_in  = a_ady[AStep-1];
            end
            else
            begin : g_next
                assign rem_in  = {{(63-RootBW){1'b0}}, b_rem[k-1]};
                assign root_in = {{(32-RootBW){1'b0}}, b_root[k-1]};
                assign ra_in   = b_ra[k-1];
                assign s_in    = b_s[k-1];
                assign adx_in  = b_adx[k-1];
                assign ady_in  = b_ady[k-1];
            end
            assign rad = {1'b0, ra_in};
            assign st  = sqrt_step(rem_in, root_in, rad[31-2*k -: 2]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    b_rem[k]  <= st.rem[RootBW:0];
                    b_root[k] <= st.root[RootBW-1:0];
                    b_ra[k]   <= ra_in;
                    b_s[k]    <= s_in;
                    b_adx[k]  <= adx_in;
                    b_ady[k]  <= ady_in;
                end
            end
        end
    endgenerate

    // Denominator S * R
    logic [DenW-1:0] den_reg;
    logic [AbsW-1:0] m_adx_reg, m_ady_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= DenW'(b_s[BStep-1] * b_root[BStep-1]);
            m_adx_reg <= b_adx[BStep-1];
            m_ady_reg <= b_ady[BStep-1];
        end
    end

    // Field dividers: |d| * 2^35 / (S * R), both components side by side
    logic [DenW-1:0] dx_rem[DivStep];
    logic [DenW-1:0] dy_rem[DivStep];
    logic [QW-1:0]   qx_q  [DivStep];
    logic [QW-1:0]   qy_q  [DivStep];
    logic [DenW-1:0] d_den [DivStep];

    generate
        for (k = 0; k < DivStep; k++)
        begin : g_div
            logic [63:0]     rx_in, ry_in, den_in;
            logic [QW-1:0]   qx_in, qy_in;
            dv_t             sx, sy;
            if (k == 0)
            begin : g_first
                assign rx_in  = {{(64-AbsW-6){1'b0}}, m_adx_reg, 6'b0};
                assign ry_in  = {{(64-AbsW-6){1'b0}}, m_ady_reg, 6'b0};
                assign den_in = {{(64-DenW){1'b0}}, den_reg};
                assign qx_in  = '0;
                assign qy_in  = '0;
            end
            else
            begin : g_next
                assign rx_in  = {{(64-DenW){1'b0}}, dx_rem[k-1]};
                assign ry_in  = {{(64-DenW){1'b0}}, dy_rem[k-1]};
                assign den_in = {{(64-DenW){1'b0}}, d_den[k-1]};
                assign qx_in  = qx_q[k-1];
                assign qy_in  = qy_q[k-1];
            end
            assign sx = div_step(rx_in, den_in, 1'b0);
            assign sy = div_step(ry_in, den_in, 1'b0);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dx_rem[k] <= sx.rem[DenW-1:0];
                    dy_rem[k] <= sy.rem[DenW-1:0];
                    qx_q[k]   <= {qx_in[QW-2:0], sx.q};
                    qy_q[k]   <= {qy_in[QW-2:0], sy.q};
                    d_den[k]  <= den_in[DenW-1:0];
                end
            end
        end
    endgenerate

    // Squares, then their sum
    logic [MagSqW-1:0] px_reg, py_reg, psum_reg;
    logic [QW-1:0]     sq_qx_reg, sq_qy_reg, sm_qx_reg, sm_qy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= MagSqW'(qx_q[DivStep-1] * qx_q[DivStep-1]);
            py_reg    <= MagSqW'(qy_q[DivStep-1] * qy_q[DivStep-1]);
            sq_qx_reg <= qx_q[DivStep-1];
            sq_qy_reg <= qy_q[DivStep-1];
            psum_reg  <= px_reg + py_reg;
            sm_qx_reg <= sq_qx_reg;
            sm_qy_reg <= sq_qy_reg;
        end
    end

    // Square root C: field magnitude
    logic [QW:0]       c_rem [CStep];
    logic [QW-1:0]     c_root[CStep];
    logic [MagSqW-1:0] c_rad [CStep];
    logic [QW-1:0]     c_qx  [CStep];
    logic [QW-1:0]     c_qy  [CStep];

    generate
        for (k = 0; k < CStep; k++)
        begin : g_sqc
            logic [63:0]       rem_in;
            logic [31:0]       root_in;
            logic [MagSqW-1:0] rad;
            logic [QW-1:0]     qx_in, qy_in;
            sq_t               st;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad     = psum_reg;
                assign qx_in   = sm_qx_reg;
                assign qy_in   = sm_qy_reg;
            end
            else
            begin : g_next
                assign rem_in  = {{(63-QW){1'b0}}, c_rem[k-1]};
                assign root_in = {{(32-QW){1'b0}}, c_root[k-1]};
                assign rad     = c_rad[k-1];
                assign qx_in   = c_qx[k-1];
                assign qy_in   = c_qy[k-1];
            end
            assign st = sqrt_step(rem_in, root_in, rad[MagSqW-1-2*k -: 2]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_rem[k]  <= st.rem[QW:0];
                    c_root[k] <= st.root[QW-1:0];
                    c_rad[k]  <= rad;
                    c_qx[k]   <= qx_in;
                    c_qy[k]   <= qy_in;
                end
            end
        end
    endgenerate

    // Potential divider: 2^48 / S
    logic [SqW-1:0]   pd_rem[PDivStep];
    logic [PotQW-1:0] pd_q  [PDivStep];
    logic [SqW-1:0]   pd_s  [PDivStep];

    generate
        for (k = 0; k < PDivStep; k++)
        begin : g_pdiv
            logic [63:0]      rem_in, den_in;
            logic [PotQW-1:0] q_in;
            dv_t              st;
            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign den_in = {{(64-SqW){1'b0}}, s_reg};
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = {{(64-SqW){1'b0}}, pd_rem[k-1]};
                assign den_in = {{(64-SqW){1'b0}}, pd_s[k-1]};
                assign q_in   = pd_q[k-1];
            end
            assign st = div_step(rem_in, den_in, (k == 0) ? 1'b1 : 1'b0);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pd_rem[k] <= st.rem[SqW-1:0];
                    pd_q[k]   <= {q_in[PotQW-2:0], st.q};
                    pd_s[k]   <= den_in[SqW-1:0];
                end
            end
        end
    endgenerate

    // Potential square root
    logic [PotW:0]    ps_rem [PSqStep];
    logic [PotW-1:0]  ps_root[PSqStep];
    logic [PotQW-1:0] ps_q   [PSqStep];

    generate
        for (k = 0; k < PSqStep; k++)
        begin : g_psq
            logic [63:0]      rem_in;
            logic [31:0]      root_in;
            logic [PotQW-1:0] q_in;
            logic [PotQW:0]   rad;
            sq_t              st;
            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign q_in    = pd_q[PDivStep-1];
            end
            else
            begin : g_next
                assign rem_in  = {{(63-PotW){1'b0}}, ps_rem[k-1]};
                assign root_in = {{(32-PotW){1'b0}}, ps_root[k-1]};
                assign q_in    = ps_q[k-1];
            end
            assign rad = {1'b0, q_in};
            assign st  = sqrt_step(rem_in, root_in, rad[PotQW-2*k -: 2]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ps_rem[k]  <= st.rem[PotW:0];
                    ps_root[k] <= st.root[PotW-1:0];
                    ps_q[k]    <= q_in;
                end
            end
        end
    endgenerate

    // Hold the potential until the field path catches up
    logic [PotW-1:0] pdl_reg[PDelay];

    generate
        for (k = 0; k < PDelay; k++)
        begin : g_pdl
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (k == 0)
                    begin
                        pdl_reg[k] <= ps_root[PSqStep-1];
                    end
                    else
                    begin
                        pdl_reg[k] <= pdl_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    endgenerate

    // Gather the finished item
    always_comb
    begin
        res.zero = info_reg[FieldLen-1].zero;
        res.nx   = info_reg[FieldLen-1].nx;
        res.ny   = info_reg[FieldLen-1].ny;
        res.neg  = info_reg[FieldLen-1].neg;
        res.qx   = c_qx[CStep-1];
        res.qy   = c_qy[CStep-1];
        res.mag  = c_root[CStep-1];
        res.pot  = pdl_reg[PDelay-1];
    end

    pcf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (info_reg[FieldLen-1].v),
        .res       (res),
        .adv       (en),
        .result    (result)
    );

endmodule

### hdl/pcf_out_stage.sv
// Output register: applies signs and the coincident-point rule, holds the item until taken.
module pcf_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  pcf_pkg::res_t    res,
    output logic             adv,
    pcf_out_if.source        result
);
    import pcf_pkg::*;

    logic                      valid_reg;
    logic signed [FieldW-1:0]  fx_reg;
    logic signed [FieldW-1:0]  fy_reg;
    logic [MagW-1:0]           mag_reg;
    logic signed [PotOutW-1:0] pot_reg;
    logic signed [FieldW-1:0]  fx_next;
    logic signed [FieldW-1:0]  fy_next;
    logic [MagW-1:0]           mag_next;
    logic signed [PotOutW-1:0] pot_next;
    logic [FieldW-1:0]         ux;
    logic [FieldW-1:0]         uy;
    logic [PotOutW-1:0]        up;

    // Advance whenever the held item is gone or being taken
    assign adv = !valid_reg || result.ready;

    // Apply signs, zero everything for a point on the charge
    always_comb
    begin
        ux = {{(FieldW-QW){1'b0}}, res.qx};
        uy = {{(FieldW-QW){1'b0}}, res.qy};
        up = {{(PotOutW-PotW){1'b0}}, res.pot};
        fx_next  = res.nx ? -ux : ux;
        fy_next  = res.ny ? -uy : uy;
        mag_next = {{(MagW-QW){1'b0}}, res.mag};
        pot_next = res.neg ? -up : up;
        if (res.zero)
        begin
            fx_next  = '0;
            fy_next  = '0;
            mag_next = '0;
            pot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            mag_reg <= mag_next;
            pot_reg <= pot_next;
        end
    end

    assign result.valid           = valid_reg;
    assign result.field_x         = fx_reg;
    assign result.field_y         = fy_reg;
    assign result.field_magnitude = mag_reg;
    assign result.potential_value = pot_reg;

endmodule
